### hdl/pfe_pkg.sv
// Shared types and constants for the protocol buffer field encoder.
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int KIND_W      = 2;
    localparam int FNUM_W      = 32;
    localparam int VALUE_W     = 64;
    localparam int BYTE_W      = 8;
    localparam int TAG_SHIFT   = 3;
    localparam int TAG_W       = FNUM_W + TAG_SHIFT;
    localparam int GROUP_W     = 7;
    localparam int TAG_GROUPS  = (TAG_W + GROUP_W - 1) / GROUP_W;
    localparam int VAL_GROUPS  = (VALUE_W + GROUP_W - 1) / GROUP_W;
    localparam int TAG_CNT_W   = $clog2(TAG_GROUPS + 1);
    localparam int VAL_CNT_W   = $clog2(VAL_GROUPS + 1);

    localparam logic [KIND_W-1:0] KIND_VARINT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [TAG_SHIFT-1:0] WIRE_VARINT = 3'd0;
    localparam logic [TAG_SHIFT-1:0] WIRE_BYTES  = 3'd2;

    // One item as the serialiser sees it; a payload byte sits in val[7:0].
    typedef struct packed {
        logic                 is_payload;
        logic [TAG_W-1:0]     tag;
        logic [TAG_CNT_W-1:0] tag_cnt;
        logic [VALUE_W-1:0]   val;
        logic [VAL_CNT_W-1:0] val_cnt;
    } pfe_item_t;

endpackage

### hdl/protobuf_field_encoder_unit.sv
// Protocol buffer varint field encoder: top level with input and count stages.
// An item passes stage 1 and stage 2 into the serialiser's item register, which drives
// the output; it stays there until its last byte is taken, and yields 1 to 15 bytes
// (tag varint 1-5 plus value varint 1-10, or one payload byte); kind 3 yields none.
// The two front stages take a new item each cycle while the serialiser has room.
// Reset (aresetn low, synchronous) empties every stage; there is no other state.
`timescale 1ns / 1ps

module protobuf_field_encoder_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_kind,
    input  logic [31:0]  s_field_number,
    input  logic [63:0]  s_value,
    input  logic [7:0]   s_payload_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_out_byte,
    output logic         m_last
);

    // Stage 1: tag assembled.
    logic                        s1_valid_reg;
    logic                        s1_payload_reg;
    logic [pfe_pkg::TAG_W-1:0]   s1_tag_reg;
    logic [pfe_pkg::VALUE_W-1:0] s1_value_reg;
    logic [7:0]                  s1_byte_reg;
    logic                        s1_ready;

    // Stage 2: byte counts resolved.
    logic                        s2_valid_reg;
    pfe_pkg::pfe_item_t          s2_item_reg;
    pfe_pkg::pfe_item_t          s2_item_next;
    logic                        s2_ready;
    logic                        ser_ready;

    logic [pfe_pkg::TAG_SHIFT-1:0] wire_type;
    logic                          kind_known;

    assign s2_ready = !s2_valid_reg || ser_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    assign wire_type  = (s_kind == pfe_pkg::KIND_HEADER) ? pfe_pkg::WIRE_BYTES
                                                         : pfe_pkg::WIRE_VARINT;
    // Kind 3 is taken but produces nothing, so it never enters the pipe.
    assign kind_known = s_kind inside {pfe_pkg::KIND_VARINT, pfe_pkg::KIND_HEADER,
                                       pfe_pkg::KIND_PAYLOAD};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid && kind_known;
        end
        if (s1_ready) begin
            s1_payload_reg <= (s_kind == pfe_pkg::KIND_PAYLOAD);
            s1_tag_reg     <= {s_field_number, wire_type};
            s1_value_reg   <= s_value;
            s1_byte_reg    <= s_payload_byte;
        end
    end

    // Byte count of a varint is the index of the highest non-zero 7-bit group plus one.
    always_comb begin
        s2_item_next            = '0;
        s2_item_next.is_payload = s1_payload_reg;
        if (s1_payload_reg) begin
            s2_item_next.tag_cnt = '0;
            s2_item_next.val     = {{(pfe_pkg::VALUE_W-8){1'b0}}, s1_byte_reg};
            s2_item_next.val_cnt = pfe_pkg::VAL_CNT_W'(1);
        end else begin
            s2_item_next.tag     = s1_tag_reg;
            s2_item_next.val     = s1_value_reg;
            s2_item_next.tag_cnt = pfe_pkg::TAG_CNT_W'(1);
            for (int g = 1; g < pfe_pkg::TAG_GROUPS; g++) begin
                if ((s1_tag_reg >> (pfe_pkg::GROUP_W * g)) != '0) begin
                    s2_item_next.tag_cnt = pfe_pkg::TAG_CNT_W'(g + 1);
                end
            end
            s2_item_next.val_cnt = pfe_pkg::VAL_CNT_W'(1);
            for (int g = 1; g < pfe_pkg::VAL_GROUPS; g++) begin
                if ((s1_value_reg >> (pfe_pkg::GROUP_W * g)) != '0) begin
                    s2_item_next.val_cnt = pfe_pkg::VAL_CNT_W'(g + 1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready) begin
            s2_item_reg <= s2_item_next;
        end
    end

    pfe_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s2_valid_reg),
        .in_item    (s2_item_reg),
        .in_ready   (ser_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

`ifndef ASSERT_OFF
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !ser_ready) |=> (s2_valid_reg && $stable(s2_item_reg)))
        else $error("stalled stage 2 item changed");
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_tag_reg)))
        else $error("stalled stage 1 item changed");
    a_s2_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_item_reg.is_payload) |->
            (s2_item_reg.tag_cnt == '0 && s2_item_reg.val_cnt == 1))
        else $error("payload item with varint counts");
`endif

endmodule

### hdl/pfe_serializer.sv
// Serialiser: tag then value varint, or a payload byte; one beat per cycle if m_ready.
`timescale 1ns / 1ps

module pfe_serializer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  pfe_pkg::pfe_item_t    in_item,
    output logic                  in_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last
);

    logic               busy_reg;
    logic               busy_next;
    pfe_pkg::pfe_item_t item_reg;
    pfe_pkg::pfe_item_t item_next;
    logic               in_tag;

    assign in_tag  = (item_reg.tag_cnt != '0);
    assign m_valid = busy_reg;
    assign m_last  = !in_tag && (item_reg.is_payload || item_reg.val_cnt == 1);

    always_comb begin
        if (in_tag) begin
            m_out_byte = {item_reg.tag_cnt != 1, item_reg.tag[pfe_pkg::GROUP_W-1:0]};
        end else if (item_reg.is_payload) begin
            m_out_byte = item_reg.val[pfe_pkg::BYTE_W-1:0];
        end else begin
            m_out_byte = {item_reg.val_cnt != 1, item_reg.val[pfe_pkg::GROUP_W-1:0]};
        end
    end

    // A new item may be loaded in the same cycle as the final beat of the previous one.
    assign in_ready = !busy_reg || (m_ready && m_last);

    always_comb begin
        busy_next = busy_reg;
        item_next = item_reg;
        if (busy_reg && m_ready) begin
            if (m_last) begin
                busy_next = 1'b0;
            end else if (in_tag) begin
                item_next.tag     = item_reg.tag >> pfe_pkg::GROUP_W;
                item_next.tag_cnt = item_reg.tag_cnt - 1'b1;
            end else begin
                item_next.val     = item_reg.val >> pfe_pkg::GROUP_W;
                item_next.val_cnt = item_reg.val_cnt - 1'b1;
            end
        end
        if (in_valid && in_ready) begin
            busy_next = 1'b1;
            item_next = in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        item_reg <= item_next;
    end

`ifndef ASSERT_OFF
    a_val_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (item_reg.val_cnt != '0))
        else $error("serialiser busy with an empty value count");
    a_tag_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (item_reg.tag_cnt <= pfe_pkg::TAG_GROUPS))
        else $error("tag byte count out of range");
    a_val_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (item_reg.val_cnt <= pfe_pkg::VAL_GROUPS))
        else $error("value byte count out of range");
    a_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("item ended without a last beat");
    a_no_load_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !(m_ready && m_last)) |-> !in_ready)
        else $error("serialiser accepted an item mid-stream");
`endif

endmodule

### tb/sv/protobuf_field_encoder_unit_tb.sv
// Self-checking testbench for the protocol buffer field encoder unit.
`timescale 1ns / 1ps

module protobuf_field_encoder_unit_tb;

    localparam logic [pfe_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [63:0]       GROUP_MASK  = 64'h7f;
    localparam int                RANDOM_ITEMS = 400;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    // Predicts the encoded byte stream and checks the output against it.
    class field_byte_board;
        enc_byte_t expected_q[$];
        int        errors;
        int        checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function void push_varint(logic [63:0] v, logic final_group);
            logic [63:0] rest;
            enc_byte_t   b;
            rest = v;
            while (rest > GROUP_MASK) begin
                b.data = {1'b1, rest[6:0]};
                b.last = 1'b0;
                expected_q.push_back(b);
                rest = rest >> pfe_pkg::GROUP_W;
            end
            b.data = rest[7:0];
            b.last = final_group;
            expected_q.push_back(b);
        endfunction

        function void note_item(logic [1:0] kind, logic [31:0] fnum,
                                logic [63:0] value, logic [7:0] pb);
            enc_byte_t b;
            case (kind)
                pfe_pkg::KIND_VARINT: begin
                    push_varint({29'd0, fnum, pfe_pkg::WIRE_VARINT}, 1'b0);
                    push_varint(value, 1'b1);
                end
                pfe_pkg::KIND_HEADER: begin
                    push_varint({29'd0, fnum, pfe_pkg::WIRE_BYTES}, 1'b0);
                    push_varint(value, 1'b1);
                end
                pfe_pkg::KIND_PAYLOAD: begin
                    b.data = pb;
                    b.last = 1'b1;
                    expected_q.push_back(b);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            enc_byte_t b;
            if (expected_q.size() == 0) begin
                $error("unexpected output beat: out_byte=%h last=%b", data, last);
                errors++;
                return;
            end
            b = expected_q.pop_front();
            checked++;
            if (data !== b.data) begin
                $error("out_byte mismatch: expected %h, actual %h", b.data, data);
                errors++;
            end
            if (last !== b.last) begin
                $error("last mismatch: expected %b, actual %b", b.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [31:0] s_field_number;
    logic [63:0] s_value;
    logic [7:0]  s_payload_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_last;

    field_byte_board board;
    bit          no_idle;
    int          kind_count[4];

    protobuf_field_encoder_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_field_number (s_field_number),
        .s_value        (s_value),
        .s_payload_byte (s_payload_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last         (m_last)
    );

    always #1 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand_bits(int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (bits >= 64) return v;
        return v & ((64'd1 << bits) - 64'd1);
    endfunction

    // Called from a rising edge; returns at the rising edge where the beat is taken.
    task automatic drive_item(logic [1:0] kind, logic [31:0] fnum,
                              logic [63:0] value, logic [7:0] pb);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_kind         = kind;
        s_field_number = fnum;
        s_value        = value;
        s_payload_byte = pb;
        do @(posedge aclk); while (!s_ready);
        board.note_item(kind, fnum, value, pb);
        kind_count[kind]++;
    endtask

    task automatic drain_outputs();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic random_field(logic [1:0] kind);
        drive_item(kind, 32'(rand_bits($urandom_range(0, 32))),
                   rand_bits($urandom_range(0, 64)), 8'($urandom_range(0, 255)));
    endtask

    // A bytes header followed by its payload; some sequences are cut short.
    task automatic random_bytes_field(inout int sent);
        int len;
        int n;
        len = $urandom_range(0, 12);
        n   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        drive_item(pfe_pkg::KIND_HEADER, 32'(rand_bits($urandom_range(0, 32))), 64'(len),
                   8'($urandom_range(0, 255)));
        sent++;
        for (int i = 0; i < n; i++) begin
            drive_item(pfe_pkg::KIND_PAYLOAD, {$urandom}, {$urandom, $urandom},
                       8'($urandom_range(0, 255)));
            sent++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_byte(m_out_byte, m_last);
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = pick_gap();
            @(negedge aclk);
            if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
        end
    end

    initial begin
        #4_000_000;
        $display("[protobuf_field_encoder_unit] ERROR");
        $finish;
    end

    initial begin
        int sent;
        int r;
        board          = new();
        no_idle        = 1'b0;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = pfe_pkg::KIND_VARINT;
        s_field_number = '0;
        s_value        = '0;
        s_payload_byte = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // Directed: zero and full-scale fields, varint group boundaries, every kind.
        drive_item(pfe_pkg::KIND_VARINT, 32'd0, 64'd0, 8'hff);
        drive_item(pfe_pkg::KIND_VARINT, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'h00);
        drive_item(pfe_pkg::KIND_VARINT, 32'd15, 64'd127, 8'h00);
        drive_item(pfe_pkg::KIND_VARINT, 32'd16, 64'd128, 8'h00);
        drive_item(pfe_pkg::KIND_VARINT, 32'd2047, 64'd16383, 8'h00);
        drive_item(pfe_pkg::KIND_VARINT, 32'd2048, 64'd16384, 8'h00);
        drive_item(pfe_pkg::KIND_VARINT, 32'h1fff_ffff, 64'h8000_0000_0000_0000, 8'h00);
        drive_item(pfe_pkg::KIND_VARINT, 32'h2000_0000, 64'h00ff_ffff_ffff_ffff, 8'h00);
        drive_item(pfe_pkg::KIND_HEADER, 32'd0, 64'd0, 8'haa);
        drive_item(pfe_pkg::KIND_HEADER, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'h55);
        drive_item(pfe_pkg::KIND_HEADER, 32'd1, 64'd3, 8'h00);
        drive_item(pfe_pkg::KIND_PAYLOAD, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'h00);
        drive_item(pfe_pkg::KIND_PAYLOAD, 32'd0, 64'd0, 8'hff);
        drive_item(pfe_pkg::KIND_PAYLOAD, 32'd0, 64'd0, 8'h80);
        drive_item(KIND_UNUSED, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff);
        drive_item(pfe_pkg::KIND_PAYLOAD, 32'd0, 64'd0, 8'h7f);
        drive_item(KIND_UNUSED, 32'd0, 64'd0, 8'h00);
        no_idle = 1'b1;
        drive_item(pfe_pkg::KIND_VARINT, 32'hffff_ffff, 64'd1, 8'h00);
        drive_item(pfe_pkg::KIND_PAYLOAD, 32'd0, 64'd0, 8'h01);
        drive_item(pfe_pkg::KIND_HEADER, 32'd5, 64'd300, 8'h00);
        no_idle = 1'b0;
        drain_outputs();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 3)
                drain_outputs();
            r = $urandom_range(0, 99);
            if (r < 40) begin
                random_field(pfe_pkg::KIND_VARINT);
                sent++;
            end else if (r < 70) begin
                random_bytes_field(sent);
            end else if (r < 80) begin
                random_field(pfe_pkg::KIND_HEADER);
                sent++;
            end else if (r < 96) begin
                drive_item(pfe_pkg::KIND_PAYLOAD, {$urandom}, {$urandom, $urandom},
                           8'($urandom_range(0, 255)));
                sent++;
            end else begin
                random_field(KIND_UNUSED);
            end
        end
        no_idle = 1'b0;
        drain_outputs();
        repeat (20) @(posedge aclk);

        $display("Stimulus: %0d varint fields, %0d bytes headers, %0d payload bytes, %0d ignored.",
                 kind_count[pfe_pkg::KIND_VARINT], kind_count[pfe_pkg::KIND_HEADER],
                 kind_count[pfe_pkg::KIND_PAYLOAD], kind_count[KIND_UNUSED]);
        $display("Checked %0d encoded output bytes against the predicted stream.", board.checked);
        if (board.errors == 0 && board.pending() == 0)
            $display("[protobuf_field_encoder_unit] OK");
        else
            $display("[protobuf_field_encoder_unit] ERROR");
        $finish;
    end

endmodule
